// ----- rtl/glcw_pkg.sv -----
// ----------------------------------------------------------------------------
// glcw_pkg
// Shared types and constants for the grid line cell walker.
// ----------------------------------------------------------------------------
package glcw_pkg;

    // coordinate width of the square grid tile
    localparam int COORD_BITS = 6;
    // signed error term, holds row_span - col_span and its updates
    localparam int ERR_BITS   = COORD_BITS + 2;

    typedef logic [COORD_BITS-1:0]      coord_t;
    typedef logic signed [ERR_BITS-1:0] err_t;

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;   // take a new ray into the walk registers
        logic emit;   // put current cell into the output register and step
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic done;   // current cell is the end cell
    } status_t;

endpackage

// ----- rtl/grid_line_cell_walker_core.sv -----
// ----------------------------------------------------------------------------
// grid_line_cell_walker_core
// All-octant Bresenham line walker over a 64 x 64 cell tile.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one word per ray, start cell and end cell (row, col).
//   Output channel m_*: one word per cell on the line, start to end in order,
//   both ends included; m_last_cell marks the end cell.
//   A ray of spans dr, dc yields max(dr, dc) + 1 cells, at most 64.
// Timing:
//   The ray is loaded into the walk registers in the cycle it is accepted; the
//   first cell then goes from the walk registers into the output register, then
//   one cell per cycle while m_ready is high. A single step unit walks one cell
//   per cycle, so a ray is finished before the next one is taken.
//   s_ready is high only between rays; the next ray may be taken while the
//   end cell still waits in the output register.
// Reset:
//   aresetn (synchronous, active low) returns the sequencer to idle and drops
//   m_valid; no clearing pass is needed.
// Stalls:
//   While m_valid is high and m_ready is low the output word holds and the walk pauses in place.
// ----------------------------------------------------------------------------
module grid_line_cell_walker_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  glcw_pkg::coord_t    s_start_row,
    input  glcw_pkg::coord_t    s_start_col,
    input  glcw_pkg::coord_t    s_end_row,
    input  glcw_pkg::coord_t    s_end_col,
    output logic                m_valid,
    input  logic                m_ready,
    output glcw_pkg::coord_t    m_cell_row,
    output glcw_pkg::coord_t    m_cell_col,
    output logic                m_last_cell
);

    glcw_pkg::cmd_t    cmd;
    glcw_pkg::status_t sts;

    // sequencer
    glcw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // walk datapath
    glcw_dpath u_dpath (
        .aclk      (aclk),
        .start_row (s_start_row),
        .start_col (s_start_col),
        .end_row   (s_end_row),
        .end_col   (s_end_col),
        .cmd       (cmd),
        .sts       (sts),
        .cell_row  (m_cell_row),
        .cell_col  (m_cell_col),
        .last_cell (m_last_cell)
    );

endmodule

// ----- rtl/glcw_dpath.sv -----
// ----------------------------------------------------------------------------
// glcw_dpath
// Walk registers, span and error term arithmetic, and the output word register.
// ----------------------------------------------------------------------------
module glcw_dpath (
    input  logic                aclk,
    input  glcw_pkg::coord_t    start_row,
    input  glcw_pkg::coord_t    start_col,
    input  glcw_pkg::coord_t    end_row,
    input  glcw_pkg::coord_t    end_col,
    input  glcw_pkg::cmd_t      cmd,
    output glcw_pkg::status_t   sts,
    output glcw_pkg::coord_t    cell_row,
    output glcw_pkg::coord_t    cell_col,
    output logic                last_cell
);

    localparam int EW = glcw_pkg::ERR_BITS;

    glcw_pkg::coord_t walk_row_reg,   walk_row_next;
    glcw_pkg::coord_t walk_col_reg,   walk_col_next;
    glcw_pkg::coord_t target_row_reg, target_row_next;
    glcw_pkg::coord_t target_col_reg, target_col_next;
    glcw_pkg::coord_t row_span_reg,   row_span_next;
    glcw_pkg::coord_t col_span_reg,   col_span_next;
    logic             row_neg_reg,    row_neg_next;
    logic             col_neg_reg,    col_neg_next;
    glcw_pkg::err_t   err_reg,        err_next;
    glcw_pkg::coord_t out_row_reg,    out_row_next;
    glcw_pkg::coord_t out_col_reg,    out_col_next;
    logic             out_last_reg,   out_last_next;

    logic                  done;
    logic signed [EW:0]    e2;
    logic signed [EW:0]    dr_ext;
    logic signed [EW:0]    dc_ext;
    logic                  row_adv;
    logic                  col_adv;
    glcw_pkg::coord_t      ld_row_span;
    glcw_pkg::coord_t      ld_col_span;

    // end-of-walk detect
    assign done = (walk_row_reg == target_row_reg) && (walk_col_reg == target_col_reg);
    assign sts.done = done;

    // step decisions from doubled error term
    assign e2     = {err_reg, 1'b0};
    assign dr_ext = $signed({3'b000, row_span_reg});
    assign dc_ext = $signed({3'b000, col_span_reg});
    assign row_adv = (e2 > -dc_ext);
    assign col_adv = (e2 < dr_ext);

    // spans of a new ray
    assign ld_row_span = (end_row > start_row) ? end_row - start_row : start_row - end_row;
    assign ld_col_span = (end_col > start_col) ? end_col - start_col : start_col - end_col;

    // next-state of the walk registers
    always_comb begin
        walk_row_next   = walk_row_reg;
        walk_col_next   = walk_col_reg;
        target_row_next = target_row_reg;
        target_col_next = target_col_reg;
        row_span_next   = row_span_reg;
        col_span_next   = col_span_reg;
        row_neg_next    = row_neg_reg;
        col_neg_next    = col_neg_reg;
        err_next        = err_reg;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        out_last_next   = out_last_reg;
        if (cmd.load) begin
            walk_row_next   = start_row;
            walk_col_next   = start_col;
            target_row_next = end_row;
            target_col_next = end_col;
            row_span_next   = ld_row_span;
            col_span_next   = ld_col_span;
            row_neg_next    = !(start_row < end_row);
            col_neg_next    = !(start_col < end_col);
            err_next        = $signed({2'b00, ld_row_span}) - $signed({2'b00, ld_col_span});
        end else if (cmd.emit) begin
            out_row_next  = walk_row_reg;
            out_col_next  = walk_col_reg;
            out_last_next = done;
            if (!done) begin
                if (row_adv) begin
                    walk_row_next = row_neg_reg ? walk_row_reg - 1'b1 : walk_row_reg + 1'b1;
                end
                if (col_adv) begin
                    walk_col_next = col_neg_reg ? walk_col_reg - 1'b1 : walk_col_reg + 1'b1;
                end
                err_next = err_reg
                         - (row_adv ? dc_ext[EW-1:0] : glcw_pkg::err_t'(0))
                         + (col_adv ? dr_ext[EW-1:0] : glcw_pkg::err_t'(0));
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        walk_row_reg   <= walk_row_next;
        walk_col_reg   <= walk_col_next;
        target_row_reg <= target_row_next;
        target_col_reg <= target_col_next;
        row_span_reg   <= row_span_next;
        col_span_reg   <= col_span_next;
        row_neg_reg    <= row_neg_next;
        col_neg_reg    <= col_neg_next;
        err_reg        <= err_next;
        out_row_reg    <= out_row_next;
        out_col_reg    <= out_col_next;
        out_last_reg   <= out_last_next;
    end

    assign cell_row  = out_row_reg;
    assign cell_col  = out_col_reg;
    assign last_cell = out_last_reg;

endmodule

// ----- rtl/glcw_ctrl.sv -----
// ----------------------------------------------------------------------------
// glcw_ctrl
// Walk sequencer: takes a ray, issues one emit per free output slot, and owns
// the output word valid flag.
// ----------------------------------------------------------------------------
module glcw_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  glcw_pkg::status_t   sts,
    output glcw_pkg::cmd_t      cmd
);

    glcw_pkg::state_t state_reg, state_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free;

    assign out_free = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            glcw_pkg::ST_IDLE: begin
                if (s_valid) state_next = glcw_pkg::ST_WALK;
            end
            glcw_pkg::ST_WALK: begin
                if (out_free && sts.done) state_next = glcw_pkg::ST_IDLE;
            end
            default: state_next = glcw_pkg::ST_IDLE;
        endcase
    end

    // outputs and commands
    always_comb begin
        s_ready  = 1'b0;
        cmd.load = 1'b0;
        cmd.emit = 1'b0;
        unique case (state_reg)
            glcw_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            glcw_pkg::ST_WALK: begin
                cmd.emit = out_free;
            end
            default: ;
        endcase
    end

    // output word valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit) m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= glcw_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    // a taken ray starts a walk
    a_load_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == glcw_pkg::ST_WALK))
        else $error("ray accepted but walk not started");

    // the end cell closes the walk and is left in the output word
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && sts.done) |=> (state_reg == glcw_pkg::ST_IDLE) && m_valid_reg)
        else $error("end cell emitted without ending walk");

    // a stalled output word holds the walk in place
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == glcw_pkg::ST_WALK && m_valid_reg && !m_ready)
            |=> (state_reg == glcw_pkg::ST_WALK) && m_valid_reg)
        else $error("walk advanced while output stalled");
`endif

endmodule

// ----- dv/grid_line_cell_walker_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_line_cell_walker_core_test
// Self-checking bench for the Bresenham cell walker: rays go in on s_*, and
// every cell word on m_* is compared with a line walked here in parallel.
// Both channels idle in random bursts; the tail of the run streams freely.
// ----------------------------------------------------------------------------

// tracks the cells still owed by accepted rays and checks each output word
class cell_tracker;

    typedef struct {
        glcw_pkg::coord_t row;
        glcw_pkg::coord_t col;
        logic             last;
    } cell_t;

    cell_t cells_due[$];
    int    mismatches;

    function new();
        mismatches = 0;
    endfunction

    function int pending();
        return cells_due.size();
    endfunction

    // walk the whole ray and queue every cell from start to end
    function void take_ray(glcw_pkg::coord_t row0, glcw_pkg::coord_t col0,
                           glcw_pkg::coord_t row1, glcw_pkg::coord_t col1);
        glcw_pkg::coord_t row;
        glcw_pkg::coord_t col;
        glcw_pkg::coord_t dr;
        glcw_pkg::coord_t dc;
        glcw_pkg::err_t   err;
        logic             row_down;
        logic             col_down;
        logic             at_end;
        int               e2;
        cell_t            next_due;
        row      = row0;
        col      = col0;
        dr       = (row1 > row0) ? row1 - row0 : row0 - row1;
        dc       = (col1 > col0) ? col1 - col0 : col0 - col1;
        row_down = !(row0 < row1);
        col_down = !(col0 < col1);
        err      = glcw_pkg::err_t'(dr) - glcw_pkg::err_t'(dc);
        for (int n = 0; n < (1 << glcw_pkg::COORD_BITS); n++) begin
            at_end        = (row == row1) && (col == col1);
            next_due.row  = row;
            next_due.col  = col;
            next_due.last = at_end;
            cells_due.insert(cells_due.size(), next_due);
            if (at_end)
                break;
            e2 = 2 * int'(err);
            // row step
            if (e2 > -int'(dc)) begin
                err = err - glcw_pkg::err_t'(dc);
                row = row_down ? row - 1'b1 : row + 1'b1;
            end
            // column step
            if (e2 < int'(dr)) begin
                err = err + glcw_pkg::err_t'(dr);
                col = col_down ? col - 1'b1 : col + 1'b1;
            end
        end
    endfunction

    // compare one accepted word with the oldest owed cell
    function void match_cell(glcw_pkg::coord_t row, glcw_pkg::coord_t col,
                             logic last);
        cell_t want;
        if (cells_due.size() == 0) begin
            $error("unexpected word: cell_row %0d cell_col %0d last_cell %0b",
                   row, col, last);
            mismatches++;
            return;
        end
        want = cells_due.pop_front();
        if (row !== want.row) begin
            $error("cell_row: expected %0d, actual %0d", want.row, row);
            mismatches++;
        end
        if (col !== want.col) begin
            $error("cell_col: expected %0d, actual %0d", want.col, col);
            mismatches++;
        end
        if (last !== want.last) begin
            $error("last_cell: expected %0b, actual %0b", want.last, last);
            mismatches++;
        end
    endfunction

endclass

module grid_line_cell_walker_core_test;

    localparam int RANDOM_RAYS = 100;
    localparam int CALM_RAYS   = 20;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 80;

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             s_valid     = 1'b0;
    logic             s_ready;
    glcw_pkg::coord_t s_start_row = '0;
    glcw_pkg::coord_t s_start_col = '0;
    glcw_pkg::coord_t s_end_row   = '0;
    glcw_pkg::coord_t s_end_col   = '0;
    logic             m_valid;
    logic             m_ready     = 1'b0;
    glcw_pkg::coord_t m_cell_row;
    glcw_pkg::coord_t m_cell_col;
    logic             m_last_cell;

    cell_tracker board = new();
    bit          calm  = 1'b0;
    int unsigned cycle_count = 0;

    grid_line_cell_walker_core uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_start_row (s_start_row),
        .s_start_col (s_start_col),
        .s_end_row   (s_end_row),
        .s_end_col   (s_end_col),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_cell_row  (m_cell_row),
        .m_cell_col  (m_cell_col),
        .m_last_cell (m_last_cell)
    );

    always #5 aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // check every accepted output word
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.match_cell(m_cell_row, m_cell_col, m_last_cell);
    end

    // receiver: stall bursts between runs of ready, none once calm
    initial begin
        forever begin
            if (!calm && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 60)) @(posedge aclk);
        end
    end

    // one ray word, with an optional idle burst in front of it
    task automatic send_ray(input glcw_pkg::coord_t row0, input glcw_pkg::coord_t col0,
                            input glcw_pkg::coord_t row1, input glcw_pkg::coord_t col1);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_start_row <= row0;
        s_start_col <= col0;
        s_end_row   <= row1;
        s_end_col   <= col1;
        do @(posedge aclk); while (!s_ready);
        board.take_ray(row0, col0, row1, col1);
    endtask

    // a coordinate a few cells away from base, kept on the tile
    function automatic glcw_pkg::coord_t nearby(glcw_pkg::coord_t base);
        int t;
        t = int'(base) + int'($urandom_range(0, 8)) - 4;
        if (t < 0)
            t = 0;
        if (t > 63)
            t = 63;
        return glcw_pkg::coord_t'(t);
    endfunction

    task automatic wait_drained();
        while (board.pending() != 0) @(posedge aclk);
    endtask

    initial begin
        glcw_pkg::coord_t r0;
        glcw_pkg::coord_t c0;
        glcw_pkg::coord_t r1;
        glcw_pkg::coord_t c1;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: single cell, full diagonals, axis rays, all eight octants
        send_ray(6'd0,  6'd0,  6'd0,  6'd0);
        send_ray(6'd63, 6'd63, 6'd63, 6'd63);
        send_ray(6'd0,  6'd0,  6'd63, 6'd63);
        send_ray(6'd63, 6'd63, 6'd0,  6'd0);
        send_ray(6'd0,  6'd63, 6'd63, 6'd0);
        send_ray(6'd63, 6'd0,  6'd0,  6'd63);
        send_ray(6'd0,  6'd0,  6'd0,  6'd63);
        send_ray(6'd5,  6'd63, 6'd5,  6'd0);
        send_ray(6'd0,  6'd10, 6'd63, 6'd10);
        send_ray(6'd63, 6'd10, 6'd0,  6'd10);
        send_ray(6'd10, 6'd10, 6'd13, 6'd20);
        send_ray(6'd10, 6'd20, 6'd13, 6'd10);
        send_ray(6'd13, 6'd10, 6'd10, 6'd20);
        send_ray(6'd13, 6'd20, 6'd10, 6'd10);
        send_ray(6'd10, 6'd10, 6'd20, 6'd13);
        send_ray(6'd20, 6'd10, 6'd10, 6'd13);
        send_ray(6'd10, 6'd13, 6'd20, 6'd10);
        send_ray(6'd20, 6'd13, 6'd10, 6'd10);
        send_ray(6'd32, 6'd32, 6'd33, 6'd32);
        send_ray(6'd32, 6'd32, 6'd32, 6'd31);
        send_ray(6'd1,  6'd2,  6'd62, 6'd3);

        // hold off until the walker has emitted everything owed
        s_valid <= 1'b0;
        wait_drained();
        @(posedge aclk);

        // random rays of several shapes
        for (int i = 0; i < RANDOM_RAYS; i++) begin
            if (i >= RANDOM_RAYS - CALM_RAYS)
                calm = 1'b1;
            r0 = glcw_pkg::coord_t'($urandom_range(0, 63));
            c0 = glcw_pkg::coord_t'($urandom_range(0, 63));
            r1 = glcw_pkg::coord_t'($urandom_range(0, 63));
            c1 = glcw_pkg::coord_t'($urandom_range(0, 63));
            case ($urandom_range(0, 9))
                4, 5: begin
                    r1 = nearby(r0);
                    c1 = nearby(c0);
                end
                6: begin
                    if ($urandom_range(0, 1))
                        r1 = r0;
                    else
                        c1 = c0;
                end
                7: begin
                    r1 = r0;
                    c1 = c0;
                end
                8, 9: begin
                    r0 = $urandom_range(0, 1) ? 6'd63 : 6'd0;
                    c0 = $urandom_range(0, 1) ? 6'd63 : 6'd0;
                    r1 = $urandom_range(0, 1) ? 6'd63 : 6'd0;
                    c1 = $urandom_range(0, 1) ? 6'd63 : 6'd0;
                end
                default: ;
            endcase
            send_ray(r0, c0, r1, c1);
        end
        s_valid <= 1'b0;

        // let the last ray drain, then look for stray words
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/glcw_pkg.sv
rtl/glcw_dpath.sv
rtl/glcw_ctrl.sv
rtl/grid_line_cell_walker_core.sv
dv/grid_line_cell_walker_core_test.sv
